### hdl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, constants and helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH = 1024;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int DAT_W = 32;

  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_BACK  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_BACK   = 3'd3,
    ACT_CLEAR      = 3'd4,
    ACT_REVERSE    = 3'd5,
    ACT_SORT       = 3'd6,
    ACT_NOP        = 3'd7
  } act_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [DAT_W-1:0] back_value;
    logic signed [DAT_W-1:0] front_value;
    logic signed [DAT_W-1:0] removed_value;
    status_t                 status;
  } res_t;

  localparam logic [DAT_W-1:0] EMPTY_MARK = '1;
  localparam logic [CNT_W-1:0] FULL_CNT   = CNT_W'(DEPTH);

  // physical slot of a logical position (wraps on the power-of-two depth)
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                               input logic [IDX_W-1:0] pos);
    return head + pos;
  endfunction

endpackage

### hdl/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Value store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module deq_ram
  import deq_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [DAT_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [DAT_W-1:0] rd_data
);

  logic [DAT_W-1:0] mem [DEPTH];
  logic [DAT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer: runs each action against the store, then reads front and back.
// ----------------------------------------------------------------------------
module deq_ctrl
  import deq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  act_t                    in_act,
  input  logic signed [DAT_W-1:0] in_value,
  output logic                    res_valid,
  input  logic                    res_ready,
  output res_t                    res,
  output logic                    wr_en,
  output logic [IDX_W-1:0]        wr_addr,
  output logic [DAT_W-1:0]        wr_data,
  output logic                    rd_en,
  output logic [IDX_W-1:0]        rd_addr,
  input  logic [DAT_W-1:0]        rd_data
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_EXEC     = 12'b000000000010,
    S_POP_CAP  = 12'b000000000100,
    S_REV_RD_I = 12'b000000001000,
    S_REV_RD_J = 12'b000000010000,
    S_REV_WR_I = 12'b000000100000,
    S_REV_WR_J = 12'b000001000000,
    S_SRT_ST   = 12'b000010000000,
    S_SRT_PASS = 12'b000100000000,
    S_SRT_LAST = 12'b001000000000,
    S_FIN_F    = 12'b010000000000,
    S_FIN_B    = 12'b100000000000
  } state_t;

  state_t           state_r, state_nxt;
  logic             fin_o_r, fin_o_nxt;   // result stage (front/back ready)
  act_t             act_r, act_nxt;
  logic [DAT_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  status_t          status_r, status_nxt;
  logic [DAT_W-1:0] removed_r, removed_nxt;
  logic [DAT_W-1:0] front_r, front_nxt;
  logic [DAT_W-1:0] cur_r, cur_nxt;       // sort carry / reverse temp
  logic [IDX_W-1:0] k_r, k_nxt;           // sort index / reverse low index
  logic [IDX_W-1:0] j_r, j_nxt;           // reverse high index
  logic             swap_r, swap_nxt;
  logic [IDX_W-1:0] last_pos;
  logic             full, empty;

  assign last_pos = count_r[IDX_W-1:0] - 1'b1;
  assign full     = (count_r == FULL_CNT);
  assign empty    = (count_r == '0);
  assign in_ready = (state_r == S_IDLE) && !fin_o_r;

  always_comb begin
    state_nxt   = state_r;
    fin_o_nxt   = fin_o_r;
    act_nxt     = act_r;
    val_nxt     = val_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    removed_nxt = removed_r;
    front_nxt   = front_r;
    cur_nxt     = cur_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    swap_nxt    = swap_r;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = '0;
    res_valid   = 1'b0;

    if (fin_o_r) begin
      res_valid = 1'b1;
      if (res_ready) begin
        fin_o_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          act_nxt   = in_act;
          val_nxt   = in_value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        status_nxt  = ST_OK;
        removed_nxt = '0;
        state_nxt   = S_FIN_F;
        case (act_r)
          ACT_PUSH_FRONT: begin
            if (full) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              head_nxt  = head_r - 1'b1;
              wr_en     = 1'b1;
              wr_addr   = head_r - 1'b1;
              wr_data   = val_r;
              count_nxt = count_r + 1'b1;
            end
          end
          ACT_PUSH_BACK: begin
            if (full) begin
              status_nxt = ST_OVERFLOW;
            end else begin
              wr_en     = 1'b1;
              wr_addr   = slot_of(head_r, count_r[IDX_W-1:0]);
              wr_data   = val_r;
              count_nxt = count_r + 1'b1;
            end
          end
          ACT_POP_FRONT: begin
            if (empty) begin
              status_nxt = ST_UNDERFLOW;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = head_r;
              head_nxt  = head_r + 1'b1;
              count_nxt = count_r - 1'b1;
              state_nxt = S_POP_CAP;
            end
          end
          ACT_POP_BACK: begin
            if (empty) begin
              status_nxt = ST_UNDERFLOW;
            end else begin
              rd_en     = 1'b1;
              rd_addr   = slot_of(head_r, last_pos);
              count_nxt = count_r - 1'b1;
              state_nxt = S_POP_CAP;
            end
          end
          ACT_CLEAR: begin
            count_nxt = '0;
            head_nxt  = '0;
          end
          ACT_REVERSE: begin
            if (count_r > CNT_W'(1)) begin
              k_nxt     = '0;
              j_nxt     = last_pos;
              state_nxt = S_REV_RD_I;
            end
          end
          ACT_SORT: begin
            if (count_r > CNT_W'(1)) begin
              state_nxt = S_SRT_ST;
            end
          end
          default: begin
          end
        endcase
      end
      S_POP_CAP: begin
        removed_nxt = rd_data;
        state_nxt   = S_FIN_F;
      end
      S_REV_RD_I: begin
        rd_en     = 1'b1;
        rd_addr   = slot_of(head_r, k_r);
        state_nxt = S_REV_RD_J;
      end
      S_REV_RD_J: begin
        rd_en     = 1'b1;
        rd_addr   = slot_of(head_r, j_r);
        cur_nxt   = rd_data;
        state_nxt = S_REV_WR_I;
      end
      S_REV_WR_I: begin
        wr_en     = 1'b1;
        wr_addr   = slot_of(head_r, k_r);
        wr_data   = rd_data;
        state_nxt = S_REV_WR_J;
      end
      S_REV_WR_J: begin
        wr_en   = 1'b1;
        wr_addr = slot_of(head_r, j_r);
        wr_data = cur_r;
        k_nxt   = k_r + 1'b1;
        j_nxt   = j_r - 1'b1;
        // continue while the next pair is still apart
        if ({1'b0, k_r} + CNT_W'(2) < {1'b0, j_r}) begin
          state_nxt = S_REV_RD_I;
        end else begin
          state_nxt = S_FIN_F;
        end
      end
      S_SRT_ST: begin
        // bubble pass: fetch position 0, carry the running maximum
        rd_en     = 1'b1;
        rd_addr   = head_r;
        k_nxt     = '0;
        swap_nxt  = 1'b0;
        state_nxt = S_SRT_PASS;
      end
      S_SRT_PASS: begin
        if (k_r == '0) begin
          cur_nxt = rd_data;
        end else if ($signed(cur_r) > $signed(rd_data)) begin
          wr_en    = 1'b1;
          wr_addr  = slot_of(head_r, k_r - 1'b1);
          wr_data  = rd_data;
          swap_nxt = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = slot_of(head_r, k_r - 1'b1);
          wr_data = cur_r;
          cur_nxt = rd_data;
        end
        if (k_r == last_pos) begin
          state_nxt = S_SRT_LAST;
        end else begin
          rd_en   = 1'b1;
          rd_addr = slot_of(head_r, k_r + 1'b1);
          k_nxt   = k_r + 1'b1;
        end
      end
      S_SRT_LAST: begin
        wr_en   = 1'b1;
        wr_addr = slot_of(head_r, last_pos);
        wr_data = cur_r;
        state_nxt = swap_r ? S_SRT_ST : S_FIN_F;
      end
      S_FIN_F: begin
        rd_en     = 1'b1;
        rd_addr   = head_r;
        state_nxt = S_FIN_B;
      end
      S_FIN_B: begin
        // wait until the previous result has left the result stage
        if (!fin_o_r) begin
          rd_en     = 1'b1;
          rd_addr   = slot_of(head_r, last_pos);
          front_nxt = rd_data;
          fin_o_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status        = status_r;
    res.removed_value = removed_r;
    res.count         = count_r;
    res.front_value   = empty ? EMPTY_MARK : front_r;
    res.back_value    = empty ? EMPTY_MARK : rd_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fin_o_r <= 1'b0;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      fin_o_r <= fin_o_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    val_r     <= val_nxt;
    status_r  <= status_nxt;
    removed_r <= removed_nxt;
    front_r   <= front_nxt;
    cur_r     <= cur_nxt;
    k_r       <= k_nxt;
    j_r       <= j_nxt;
    swap_r    <= swap_nxt;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("fill count beyond depth");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EXEC))
    else $error("accepted item not executed");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && act_r == ACT_CLEAR) |=> (count_r == '0 && head_r == '0))
    else $error("clear left entries");

  a_sort_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRT_PASS) |-> ({1'b0, k_r} < count_r))
    else $error("sort index past tail");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ready) |=> ($stable(rd_data) && fin_o_r))
    else $error("result lost while stalled");
`endif

endmodule

### hdl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Deque of signed 32-bit values in a 1024-entry circular buffer.
// ----------------------------------------------------------------------------
// Sequence: push, clear, reverse/sort of <2 entries run S_EXEC, then S_FIN_F and
//   S_FIN_B read front and back; pops add S_POP_CAP. Reverse adds S_REV_RD_I,
//   S_REV_RD_J, S_REV_WR_I, S_REV_WR_J per swapped pair; sort adds bubble passes
//   of S_SRT_ST, S_SRT_PASS per entry, S_SRT_LAST (at most count passes). A new
//   item waits for the previous; front and back re-read over the single read port.
// Reset (rst_n low, synchronous): deque empty, head at slot 0, no result pending.
module double_ended_queue
  import deq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,   // action[2:0], value[34:3], zero pad
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata   // status[1:0], removed_value[33:2],
                                   // front_value[65:34], back_value[97:66],
                                   // count[108:98], zero pad
);

  localparam int RES_W = $bits(res_t);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  res_t             out_r;
  logic             out_valid_r;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [DAT_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [DAT_W-1:0] rd_data;
  act_t             in_act;

  assign in_act = act_t'(in_tdata[2:0]);

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_act   (in_act),
    .in_value (in_tdata[34:3]),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  deq_ram u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // output register: frees the sequencer while a result waits downstream
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(112 - RES_W)'(0), out_r};

endmodule
